FILE: rtl/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg: shared constants for the interval set table
// Sizes of the interval table and the operation codes of the input stream.
// ----------------------------------------------------------------------------
package ist_pkg;

  localparam int MAX_INTERVALS = 16;
  localparam int VALUE_BITS    = 16;

  // Address of one table entry, and a count that can hold MAX_INTERVALS.
  localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CW = $clog2(MAX_INTERVALS + 1);

  // Widths of the stream fields.
  localparam int KIND_BITS   = 2;
  localparam int INVAL_BITS  = 16;
  localparam int COUNT_BITS  = 5;
  localparam int OUT_BITS    = 8;

  // Operation codes. The spare code behaves as a query.
  localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_QUERY  = 2'd2;
  localparam logic [KIND_BITS-1:0] KIND_SPARE  = 2'd3;

endpackage

FILE: rtl/interval_set_table_unit.sv
// ----------------------------------------------------------------------------
// interval_set_table_unit: sorted disjoint interval set
// Keeps a set of integers as sorted, disjoint, non-adjacent closed intervals
// in one synchronous memory, and inserts, removes or looks up one value per
// transaction.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  tdata                    tuser
//  s_axis    in         [15:0] value             [1:0] kind
//  m_axis    out        [0] was_member,          none
//                       [1] changed, [2] table_full,
//                       [7:3] interval_count
//
// A transaction is accepted, then scans the table with a read and a wait per
// entry (every entry below the value and the first one not below it),
// decides the edit, moves entries with a read and a write per entry when an
// interval is opened or closed, writes back the final entry and the count,
// and reports the result; the next one is accepted only in the idle state.
// The interval memory has a single registered read port. Reset clears the
// state, the entry count and the output valid; the memory needs no clearing
// pass. A result waiting on m_axis holds the block in its final state.
// ----------------------------------------------------------------------------
module interval_set_table_unit
  import ist_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [INVAL_BITS-1:0] s_axis_tdata_i,   // [15:0] value
  input  logic [KIND_BITS-1:0]  s_axis_tuser_i,   // [1:0] kind
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_BITS-1:0]   m_axis_tdata_o    // was_member, changed,
                                                  // table_full, interval_count
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN_RD = 3'd1;
  localparam logic [2:0] ST_SCAN_WT = 3'd2;
  localparam logic [2:0] ST_DECIDE  = 3'd3;
  localparam logic [2:0] ST_SH_RD   = 3'd4;
  localparam logic [2:0] ST_SH_WR   = 3'd5;
  localparam logic [2:0] ST_FIN     = 3'd6;
  localparam logic [2:0] ST_DONE    = 3'd7;

  localparam int EW = 2 * VALUE_BITS;

  logic [2:0]            state_q, state_d;
  logic [KIND_BITS-1:0]  kind_q, kind_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [CW-1:0]         at_q, at_d;
  logic [CW-1:0]         used_q, used_d;
  logic                  found_q, found_d;
  logic                  open_q, open_d;
  logic [VALUE_BITS-1:0] cur_low_q, cur_low_d, cur_high_q, cur_high_d;
  logic [VALUE_BITS-1:0] prev_low_q, prev_low_d, prev_high_q, prev_high_d;
  logic                  fin_en_q, fin_en_d;
  logic [AW-1:0]         fin_addr_q, fin_addr_d;
  logic [EW-1:0]         fin_data_q, fin_data_d;
  logic                  inc_q, inc_d, dec_q, dec_d;
  logic                  member_q, member_d, changed_q, changed_d, full_q, full_d;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_BITS-1:0]   out_data_q, out_data_d;

  // Memory ports.
  logic [EW-1:0]         mem_q [MAX_INTERVALS];
  logic [EW-1:0]         rd_q;
  logic                  re, we;
  logic [AW-1:0]         ra, wa;
  logic [EW-1:0]         wd;

  logic [VALUE_BITS-1:0] rd_low, rd_high;
  logic                  member, join_prev, join_next, is_full;
  logic [VALUE_BITS-1:0] v_inc, v_dec;

  assign rd_low  = rd_q[VALUE_BITS-1:0];
  assign rd_high = rd_q[EW-1:VALUE_BITS];
  assign v_inc   = val_q + 1'b1;
  assign v_dec   = val_q - 1'b1;

  // Decision terms, valid in the decide state.
  assign member    = found_q && (cur_low_q <= val_q);
  assign join_prev = (idx_q != '0) &&
                     (({1'b0, prev_high_q} + 1'b1) == {1'b0, val_q});
  assign join_next = found_q && (({1'b0, val_q} + 1'b1) == {1'b0, cur_low_q});
  assign is_full   = (used_q >= CW'(MAX_INTERVALS));

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Sequencer: scan, decide, move entries, write back, report.
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    val_d       = val_q;
    idx_d       = idx_q;
    at_d        = at_q;
    used_d      = used_q;
    found_d     = found_q;
    open_d      = open_q;
    cur_low_d   = cur_low_q;
    cur_high_d  = cur_high_q;
    prev_low_d  = prev_low_q;
    prev_high_d = prev_high_q;
    fin_en_d    = fin_en_q;
    fin_addr_d  = fin_addr_q;
    fin_data_d  = fin_data_q;
    inc_d       = inc_q;
    dec_d       = dec_q;
    member_d    = member_q;
    changed_d   = changed_q;
    full_d      = full_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    re          = 1'b0;
    we          = 1'b0;
    ra          = AW'(idx_q);
    wa          = AW'(idx_q);
    wd          = rd_q;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          kind_d  = s_axis_tuser_i;
          val_d   = VALUE_BITS'(s_axis_tdata_i);
          idx_d   = '0;
          found_d = 1'b0;
          state_d = ST_SCAN_RD;
        end
      end

      // Look for the first entry whose top end is not below the value.
      ST_SCAN_RD: begin
        if (idx_q == used_q) begin
          found_d = 1'b0;
          state_d = ST_DECIDE;
        end else begin
          re      = 1'b1;
          ra      = AW'(idx_q);
          state_d = ST_SCAN_WT;
        end
      end

      ST_SCAN_WT: begin
        if (rd_high >= val_q) begin
          found_d    = 1'b1;
          cur_low_d  = rd_low;
          cur_high_d = rd_high;
          state_d    = ST_DECIDE;
        end else begin
          prev_low_d  = rd_low;
          prev_high_d = rd_high;
          idx_d       = idx_q + 1'b1;
          state_d     = ST_SCAN_RD;
        end
      end

      // Pick the edit; entry idx_q is the first one not below the value.
      ST_DECIDE: begin
        member_d  = member;
        changed_d = 1'b0;
        full_d    = 1'b0;
        fin_en_d  = 1'b0;
        inc_d     = 1'b0;
        dec_d     = 1'b0;
        state_d   = ST_FIN;
        if (kind_q == KIND_INSERT && !member) begin
          if (join_prev && join_next) begin
            we        = 1'b1;
            wa        = AW'(idx_q - 1'b1);
            wd        = {cur_high_q, prev_low_q};
            open_d    = 1'b0;
            dec_d     = 1'b1;
            changed_d = 1'b1;
            state_d   = ST_SH_RD;
          end else if (join_prev) begin
            we        = 1'b1;
            wa        = AW'(idx_q - 1'b1);
            wd        = {val_q, prev_low_q};
            changed_d = 1'b1;
          end else if (join_next) begin
            we        = 1'b1;
            wa        = AW'(idx_q);
            wd        = {cur_high_q, val_q};
            changed_d = 1'b1;
          end else if (is_full) begin
            full_d = 1'b1;
          end else begin
            open_d     = 1'b1;
            at_d       = idx_q;
            idx_d      = used_q;
            fin_en_d   = 1'b1;
            fin_addr_d = AW'(idx_q);
            fin_data_d = {val_q, val_q};
            inc_d      = 1'b1;
            changed_d  = 1'b1;
            state_d    = ST_SH_RD;
          end
        end else if (kind_q == KIND_REMOVE && member) begin
          if (cur_low_q == cur_high_q) begin
            open_d    = 1'b0;
            dec_d     = 1'b1;
            changed_d = 1'b1;
            state_d   = ST_SH_RD;
          end else if (val_q == cur_low_q) begin
            we        = 1'b1;
            wa        = AW'(idx_q);
            wd        = {cur_high_q, v_inc};
            changed_d = 1'b1;
          end else if (val_q == cur_high_q) begin
            we        = 1'b1;
            wa        = AW'(idx_q);
            wd        = {v_dec, cur_low_q};
            changed_d = 1'b1;
          end else if (is_full) begin
            full_d = 1'b1;
          end else begin
            // Split: the lower part stays, the upper part moves in above it.
            we         = 1'b1;
            wa         = AW'(idx_q);
            wd         = {v_dec, cur_low_q};
            open_d     = 1'b1;
            at_d       = idx_q + 1'b1;
            idx_d      = used_q;
            fin_en_d   = 1'b1;
            fin_addr_d = AW'(idx_q + 1'b1);
            fin_data_d = {cur_high_q, v_inc};
            inc_d      = 1'b1;
            changed_d  = 1'b1;
            state_d    = ST_SH_RD;
          end
        end
      end

      // Move one entry up (open a gap) or down (close a gap), read here, written in the write state.
      ST_SH_RD: begin
        if (open_q) begin
          if (idx_q > at_q) begin
            re      = 1'b1;
            ra      = AW'(idx_q - 1'b1);
            state_d = ST_SH_WR;
          end else begin
            state_d = ST_FIN;
          end
        end else begin
          if ((idx_q + 1'b1) < used_q) begin
            re      = 1'b1;
            ra      = AW'(idx_q + 1'b1);
            state_d = ST_SH_WR;
          end else begin
            state_d = ST_FIN;
          end
        end
      end

      ST_SH_WR: begin
        we      = 1'b1;
        wa      = AW'(idx_q);
        wd      = rd_q;
        idx_d   = open_q ? (idx_q - 1'b1) : (idx_q + 1'b1);
        state_d = ST_SH_RD;
      end

      // Final entry write and count update.
      ST_FIN: begin
        if (fin_en_q) begin
          we = 1'b1;
          wa = fin_addr_q;
          wd = fin_data_q;
        end
        if (inc_q) begin
          used_d = used_q + 1'b1;
        end else if (dec_q) begin
          used_d = used_q - 1'b1;
        end
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_data_d  = {COUNT_BITS'(used_q), full_q, changed_q, member_q};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    val_q       <= val_d;
    idx_q       <= idx_d;
    at_q        <= at_d;
    found_q     <= found_d;
    open_q      <= open_d;
    cur_low_q   <= cur_low_d;
    cur_high_q  <= cur_high_d;
    prev_low_q  <= prev_low_d;
    prev_high_q <= prev_high_d;
    fin_en_q    <= fin_en_d;
    fin_addr_q  <= fin_addr_d;
    fin_data_q  <= fin_data_d;
    inc_q       <= inc_d;
    dec_q       <= dec_d;
    member_q    <= member_d;
    changed_q   <= changed_d;
    full_q      <= full_d;
    out_data_q  <= out_data_d;
  end

  // Interval memory: entry holds {high, low}, registered read.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem_q[ra];
    end
  end

endmodule

FILE: rtl/ist_chk.sv
// ----------------------------------------------------------------------------
// ist_chk: port checker for the interval set table
// Watches the result stream for protocol and consistency slips.
// ----------------------------------------------------------------------------
module ist_chk
  import ist_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_BITS-1:0]   m_axis_tdata_o
);

  // A result stays offered, unchanged, until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped or changed before its transaction");

  // One operation at a time: the input closes after each transaction.
  a_in_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input still open after a transaction");

  // The interval count never exceeds the table size.
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (int'(m_axis_tdata_o[7:3]) <= MAX_INTERVALS))
    else $error("interval count above table size");

  // A full table leaves the set unchanged.
  a_full_nochg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[2] && m_axis_tdata_o[1]))
    else $error("table full with a change");

  // The full flag only rises when every entry is in use.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[2] |->
      (int'(m_axis_tdata_o[7:3]) == MAX_INTERVALS))
    else $error("table full below table size");

endmodule

bind interval_set_table_unit ist_chk u_ist_chk (.*);
